@@ sv/hs2d_pkg.sv @@
// hs2d_pkg: shared types and constants for the 2D five-point stencil core.
// Configuration register map, configuration bundle and per-point control word.
// No dependencies.
package hs2d_pkg;

  localparam int COEF_W     = 18;
  localparam int ROW_W      = 16;
  localparam int COLCFG_W   = 11;
  localparam int COL_OUT_W  = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [ROW_W-1:0]    ROWS_RESET   = 16'd3;
  localparam logic [COLCFG_W-1:0] COLS_RESET   = 11'd3;
  localparam logic [COEF_W-1:0]   CENTRE_RESET = 18'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS     = 3'd0,
    CFG_GRID_COLS     = 3'd1,
    CFG_COEF_VERT     = 3'd2,
    CFG_COEF_HORZ     = 3'd3,
    CFG_COEF_CENTRE   = 3'd4,
    CFG_RED_BLACK     = 3'd5,
    CFG_COLOUR_PARITY = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_W-1:0]    grid_rows;
    logic [COLCFG_W-1:0] grid_cols;
    logic [COEF_W-1:0]   coef_vert;
    logic [COEF_W-1:0]   coef_horz;
    logic [COEF_W-1:0]   coef_centre;
    logic                red_black;
    logic                parity;
  } cfg_t;

  // Per-sample decision made at input time
  typedef struct packed {
    logic             emit;
    logic             last;
    logic             wrap;
    logic [ROW_W-1:0] row;
  } point_t;

endpackage

@@ sv/hs2d_line_ram.sv @@
// hs2d_line_ram: line buffer memory, one write port and two registered read ports.
// Each entry holds the upper and middle line samples of one column.
// No dependencies.
module hs2d_line_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ sv/hs2d_raster.sv @@
// hs2d_raster: raster position counters and the per-sample point decision
// (interior test, colour test, last point). Depends on hs2d_pkg.
module hs2d_raster #(
  parameter int MAX_COLS = 1024,
  localparam int CW = $clog2(MAX_COLS)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            grid_start,
  input  hs2d_pkg::cfg_t  cfg,
  output logic [CW-1:0]   col,
  output hs2d_pkg::point_t pt
);
  import hs2d_pkg::*;

  localparam int NW  = $clog2(MAX_COLS + 1);
  localparam int KW  = ((NW > COLCFG_W) ? NW : COLCFG_W) + 1;
  localparam int RXW = ROW_W + 1;

  logic [ROW_W-1:0] row_count, row_count_next;
  logic [CW-1:0]    col_count, col_count_next;
  logic [KW-1:0]    cfg_cols_k, cols_eff, ck, nck;
  logic [ROW_W-1:0] rows_eff, r, i;
  logic [CW-1:0]    c_raw;
  logic [RXW-1:0]   rx, nr, ix;
  logic             wrap, row_wrap, row_ok, col_ok, colour_ok, last;

  always_comb begin
    cfg_cols_k = KW'(cfg.grid_cols);
    if (cfg_cols_k < KW'(3)) begin
      cols_eff = KW'(3);
    end else if (cfg_cols_k > KW'(MAX_COLS)) begin
      cols_eff = KW'(MAX_COLS);
    end else begin
      cols_eff = cfg_cols_k;
    end
    rows_eff = (cfg.grid_rows < ROW_W'(3)) ? ROW_W'(3) : cfg.grid_rows;

    // column beyond a shrunken grid restarts at zero
    c_raw = grid_start ? '0 : col_count;
    col   = (KW'(c_raw) >= cols_eff) ? '0 : c_raw;
    r     = grid_start ? '0 : row_count;

    ck       = KW'(col);
    nck      = ck + KW'(1);
    wrap     = nck >= cols_eff;
    rx       = RXW'(r);
    nr       = rx + RXW'(1);
    row_wrap = nr >= RXW'(rows_eff);

    col_count_next = wrap ? '0 : nck[CW-1:0];
    if (!wrap) begin
      row_count_next = r;
    end else if (row_wrap) begin
      row_count_next = '0;
    end else begin
      row_count_next = nr[ROW_W-1:0];
    end

    // point produced is the one north of the incoming sample
    i         = r - ROW_W'(1);
    ix        = RXW'(i);
    row_ok    = (r >= ROW_W'(2)) && (r < rows_eff);
    col_ok    = (col != '0) && ((ck + KW'(2)) <= cols_eff);
    colour_ok = !cfg.red_black || !(i[0] ^ col[0] ^ cfg.parity);

    if (!cfg.red_black) begin
      last = (ck == cols_eff - KW'(2)) && (i == rows_eff - ROW_W'(2));
    end else if (cols_eff >= KW'(4)) begin
      last = ((ck + KW'(2)) > (cols_eff - KW'(2)))
          && ((ix + RXW'(1)) > (RXW'(rows_eff) - RXW'(2)));
    end else begin
      last = (ix + RXW'(2)) > (RXW'(rows_eff) - RXW'(2));
    end

    pt.emit = row_ok && col_ok && colour_ok;
    pt.last = last;
    pt.wrap = wrap;
    pt.row  = i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (advance) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

endmodule

@@ sv/hs2d_mac.sv @@
// hs2d_mac: stencil arithmetic. Pre-adds and three coefficient products
// (registered), then exact sum, floor shift and saturation. Depends on hs2d_pkg.
module hs2d_mac #(
  parameter int SAMPLE_BITS    = 32,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] north,
  input  logic signed [SAMPLE_BITS-1:0] south,
  input  logic signed [SAMPLE_BITS-1:0] west,
  input  logic signed [SAMPLE_BITS-1:0] east,
  input  logic signed [SAMPLE_BITS-1:0] centre,
  input  logic signed [hs2d_pkg::COEF_W-1:0] coef_vert,
  input  logic signed [hs2d_pkg::COEF_W-1:0] coef_horz,
  input  logic signed [hs2d_pkg::COEF_W-1:0] coef_centre,
  output logic        [SAMPLE_BITS-1:0] result
);
  import hs2d_pkg::*;

  localparam int PAIR_W = SAMPLE_BITS + 1;
  localparam int PW     = PAIR_W + COEF_W;
  localparam int SW     = PW + 2;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-SAMPLE_BITS+1){1'b0}},
                                            {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  logic signed [PAIR_W-1:0] vert_sum, horz_sum;
  logic signed [PW-1:0]     pv_d, ph_d, pc_d, pv, ph, pc;
  logic signed [SW-1:0]     acc, shifted;

  assign vert_sum = PAIR_W'(north) + PAIR_W'(south);
  assign horz_sum = PAIR_W'(west) + PAIR_W'(east);
  assign pv_d     = PW'(coef_vert) * PW'(vert_sum);
  assign ph_d     = PW'(coef_horz) * PW'(horz_sum);
  assign pc_d     = PW'(coef_centre) * PW'(centre);

  always_ff @(posedge clk) begin
    if (en) begin
      pv <= pv_d;
      ph <= ph_d;
      pc <= pc_d;
    end
  end

  // arithmetic shift rounds towards minus infinity
  assign acc     = SW'(pv) + SW'(ph) + SW'(pc);
  assign shifted = acc >>> COEF_FRAC_BITS;

  always_comb begin
    if (shifted > SAT_HI) begin
      result = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shifted < SAT_LO) begin
      result = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      result = shifted[SAMPLE_BITS-1:0];
    end
  end

endmodule

@@ sv/heat_stencil_2d_sweep_core.sv @@
// heat_stencil_2d_sweep_core: streaming five-point Jacobi stencil over a 2D grid.
// Depends on hs2d_pkg, hs2d_raster, hs2d_line_ram, hs2d_mac.
//
//  channel  | signals                                             | dir
//  ---------+-----------------------------------------------------+----
//  input    | in_valid, in_ready, sample, grid_start              | in
//  output   | out_valid, out_ready, new_value, row_index,         | out
//           | col_index, last_point                               |
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data           | in
//
// One sample accepted per cycle while in_ready is high; after the sample south of a point
// is accepted, its result is registered in the product register, then the result register.
// Single-ported line RAM write and 1-deep bypass close the column loop.
// Synchronous reset clears counters, west register and valids, and loads config registers
// with their reset values; line RAM contents are not cleared. Output stalls back up stage
// by stage, so samples that produce no result keep flowing while a result waits.
module heat_stencil_2d_sweep_core #(
  parameter int MAX_COLS       = 1024,
  parameter int SAMPLE_BITS    = 32,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [SAMPLE_BITS-1:0]              sample,
  input  logic                                grid_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [SAMPLE_BITS-1:0]              new_value,
  output logic [hs2d_pkg::ROW_W-1:0]          row_index,
  output logic [hs2d_pkg::COL_OUT_W-1:0]      col_index,
  output logic                                last_point,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hs2d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hs2d_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import hs2d_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int DW = 2 * SAMPLE_BITS;

  cfg_t cfg;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_rows   <= ROWS_RESET;
      cfg.grid_cols   <= COLS_RESET;
      cfg.coef_vert   <= '0;
      cfg.coef_horz   <= '0;
      cfg.coef_centre <= CENTRE_RESET;
      cfg.red_black   <= 1'b0;
      cfg.parity      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GRID_ROWS:     cfg.grid_rows   <= cfg_data[ROW_W-1:0];
        CFG_GRID_COLS:     cfg.grid_cols   <= cfg_data[COLCFG_W-1:0];
        CFG_COEF_VERT:     cfg.coef_vert   <= cfg_data[COEF_W-1:0];
        CFG_COEF_HORZ:     cfg.coef_horz   <= cfg_data[COEF_W-1:0];
        CFG_COEF_CENTRE:   cfg.coef_centre <= cfg_data[COEF_W-1:0];
        CFG_RED_BLACK:     cfg.red_black   <= cfg_data[0];
        CFG_COLOUR_PARITY: cfg.parity      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic             in_acc, s1_ready, s1_adv, s2_ready, s2_adv, out_free;
  logic             s1_v, s2_v;
  point_t           in_pt, s1_pt, s2_pt;
  logic [CW-1:0]    in_col, s1_c, s2_col;
  logic [SAMPLE_BITS-1:0] s1_sample;

  assign out_free = !out_valid || out_ready;
  assign s2_adv   = s2_v && out_free;
  assign s2_ready = !s2_v || s2_adv;
  assign s1_adv   = s1_v && (!s1_pt.emit || s2_ready);
  assign s1_ready = !s1_v || s1_adv;
  assign in_ready = s1_ready;
  assign in_acc   = in_valid && in_ready;

  hs2d_raster #(.MAX_COLS(MAX_COLS)) u_raster (
    .clk        (clk),
    .rst        (rst),
    .advance    (in_acc),
    .grid_start (grid_start),
    .cfg        (cfg),
    .col        (in_col),
    .pt         (in_pt)
  );

  // line buffers: entry holds {upper, middle}
  logic [DW-1:0]          ram_a, ram_b, ram_wdata;
  logic [SAMPLE_BITS-1:0] north, mid, east, west;

  hs2d_line_ram #(.DEPTH(MAX_COLS), .AW(CW), .DW(DW)) u_lines (
    .clk     (clk),
    .we      (s1_adv),
    .waddr   (s1_c),
    .wdata   (ram_wdata),
    .re      (in_acc),
    .raddr_a (in_col),
    .raddr_b (in_col + CW'(1)),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  // bypass for the entry written in the cycle this sample's read was taken
  logic                   fwd_v;
  logic [CW-1:0]          fwd_addr;
  logic [SAMPLE_BITS-1:0] fwd_up, fwd_mid;

  always_comb begin
    if (fwd_v && fwd_addr == s1_c) begin
      north = fwd_up;
      mid   = fwd_mid;
    end else begin
      north = ram_a[DW-1:SAMPLE_BITS];
      mid   = ram_a[SAMPLE_BITS-1:0];
    end
    if (fwd_v && fwd_addr == s1_c + CW'(1)) begin
      east = fwd_mid;
    end else begin
      east = ram_b[SAMPLE_BITS-1:0];
    end
    ram_wdata = {mid, s1_sample};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      fwd_v <= 1'b0;
      west  <= '0;
    end else begin
      if (s1_ready) begin
        s1_v <= in_valid;
      end
      if (in_acc) begin
        fwd_v <= s1_adv;
      end else if (s1_adv) begin
        fwd_v <= 1'b0;
      end
      if (s1_adv) begin
        west <= s1_pt.wrap ? '0 : mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pt     <= in_pt;
      s1_c      <= in_col;
      s1_sample <= sample;
      fwd_addr  <= s1_c;
      fwd_up    <= mid;
      fwd_mid   <= s1_sample;
    end
  end

  // arithmetic
  logic [SAMPLE_BITS-1:0] mac_result;

  hs2d_mac #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac (
    .clk         (clk),
    .en          (s1_adv && s1_pt.emit),
    .north       ($signed(north)),
    .south       ($signed(s1_sample)),
    .west        ($signed(west)),
    .east        ($signed(east)),
    .centre      ($signed(mid)),
    .coef_vert   ($signed(cfg.coef_vert)),
    .coef_horz   ($signed(cfg.coef_horz)),
    .coef_centre ($signed(cfg.coef_centre)),
    .result      (mac_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_v <= s1_v && s1_pt.emit;
      end
      if (out_free) begin
        out_valid <= s2_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_pt.emit) begin
      s2_pt  <= s1_pt;
      s2_col <= s1_c;
    end
    if (s2_adv) begin
      new_value  <= mac_result;
      row_index  <= s2_pt.row;
      col_index  <= COL_OUT_W'(s2_col);
      last_point <= s2_pt.last;
    end
  end

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    (!s1_v && !s2_v && !out_valid) |-> in_ready)
    else $error("input stalled with an empty pipeline");

  a_fwd_owner: assert property (@(posedge clk) disable iff (rst)
    fwd_v |-> s1_v)
    else $error("bypass entry live without a sample in the read stage");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s2_v))
    else $error("result raised without a point in the product stage");

  a_interior_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> row_index != '0)
    else $error("halo row reported as an updated point");

endmodule

@@ tb/tb_heat_stencil_2d_sweep_core.sv @@
// Self-checking testbench for heat_stencil_2d_sweep_core: raster grids in, updated points out.
// A predictor of its own mirrors the line buffers and checks every point.
// Depends on hs2d_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_heat_stencil_2d_sweep_core;
  import hs2d_pkg::*;

  localparam int     MAX_COLS       = 1024;
  localparam int     COEF_FRAC      = 16;
  localparam int     RANDOM_ITEMS   = 1950;
  localparam int     PIPE_SETTLE    = 8;
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam longint SAT_HI         = 64'sd2147483647;
  localparam longint SAT_LO         = -SAT_HI - 1;

  typedef struct packed {
    logic [31:0] value;
    logic        start;
  } grid_sample_t;

  typedef struct packed {
    logic [31:0]          value;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
  } stencil_point_t;

  logic                  clk;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [31:0]           sample     = '0;
  logic                  grid_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [31:0]           new_value;
  logic [ROW_W-1:0]      row_index;
  logic [COL_OUT_W-1:0]  col_index;
  logic                  last_point;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  heat_stencil_2d_sweep_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .grid_start (grid_start),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .new_value  (new_value),
    .row_index  (row_index),
    .col_index  (col_index),
    .last_point (last_point),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // register mirror, reset values
  int     grid_rows_cfg     = 3;
  int     grid_cols_cfg     = 3;
  longint coef_vert_cfg     = 0;
  longint coef_horz_cfg     = 0;
  longint coef_centre_cfg   = 65536;
  bit     red_black_cfg     = 1'b0;
  bit     colour_parity_cfg = 1'b0;

  // predictor state
  logic signed [31:0] upper_row  [MAX_COLS];
  logic signed [31:0] middle_row [MAX_COLS];
  logic signed [31:0] west_sample = '0;
  int                 row_pos     = 0;
  int                 col_pos     = 0;

  grid_sample_t   pending_samples[$];
  stencil_point_t expected_points[$];
  grid_sample_t   next_item;

  int          mismatch_count = 0;
  int          samples_sent   = 0;
  int          idle_cycles    = 0;
  int          rows_now       = 3;
  int          cols_now       = 3;
  int          gap_limit      = 0;
  int          burst_left     = 0;
  int          gap_left       = 0;
  logic [15:0] stall_pattern  = 16'hFFFF;
  logic [3:0]  stall_phase    = '0;
  logic        in_accepted    = 1'b0;
  logic        cfg_accepted   = 1'b0;

  initial begin
    for (int k = 0; k < MAX_COLS; k++) begin
      upper_row[k]  = '0;
      middle_row[k] = '0;
    end
  end

  function automatic int clamp_rows(input int raw);
    return (raw < 3) ? 3 : raw;
  endfunction

  function automatic int clamp_cols(input int raw);
    return (raw < 3) ? 3 : ((raw > MAX_COLS) ? MAX_COLS : raw);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic set_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    logic signed [COEF_W-1:0] coef;
    coef = value;
    case (idx)
      CFG_GRID_ROWS:     grid_rows_cfg = value[ROW_W-1:0];
      CFG_GRID_COLS:     grid_cols_cfg = value[COLCFG_W-1:0];
      CFG_COEF_VERT:     coef_vert_cfg = coef;
      CFG_COEF_HORZ:     coef_horz_cfg = coef;
      CFG_COEF_CENTRE:   coef_centre_cfg = coef;
      CFG_RED_BLACK:     red_black_cfg = value[0];
      CFG_COLOUR_PARITY: colour_parity_cfg = value[0];
      default: ;
    endcase
  endtask

  // One raster step: work out the point finished by this sample, then shift the lines.
  task automatic advance_grid(input logic [31:0] value, input logic start);
    int                 rows, cols, r, c, nr, nc, i;
    logic signed [31:0] s32;
    longint             north, centre, west, east, s, acc;
    bit                 last;
    stencil_point_t     point;
    rows = clamp_rows(grid_rows_cfg);
    cols = clamp_cols(grid_cols_cfg);
    s32  = value;
    s    = s32;
    if (start) begin
      r = 0;
      c = 0;
    end else begin
      r = row_pos;
      c = (col_pos >= cols) ? 0 : col_pos;
    end
    north  = upper_row[c];
    centre = middle_row[c];
    west   = west_sample;
    east   = 0;
    if (c + 1 < MAX_COLS)
      east = middle_row[c + 1];

    if (r >= 2 && r < rows && c >= 1 && c + 2 <= cols) begin
      i = r - 1;
      if (!red_black_cfg || ((i + c + colour_parity_cfg) % 2) == 0) begin
        acc = coef_vert_cfg * (north + s) + coef_horz_cfg * (west + east)
            + coef_centre_cfg * centre;
        acc = acc >>> COEF_FRAC;
        if (acc > SAT_HI)
          acc = SAT_HI;
        else if (acc < SAT_LO)
          acc = SAT_LO;
        if (!red_black_cfg)
          last = (c == cols - 2) && (i == rows - 2);
        else if (cols >= 4)
          last = (c + 2 > cols - 2) && (i + 1 > rows - 2);
        else
          last = (i + 2 > rows - 2);
        point.value = acc[31:0];
        point.row   = i[ROW_W-1:0];
        point.col   = c[COL_OUT_W-1:0];
        point.last  = last;
        expected_points.push_back(point);
      end
    end

    west_sample   = middle_row[c];
    upper_row[c]  = middle_row[c];
    middle_row[c] = value;
    nc = c + 1;
    nr = r;
    if (nc >= cols) begin
      nc          = 0;
      west_sample = '0;
      nr          = r + 1;
      if (nr >= rows)
        nr = 0;
    end
    row_pos = nr;
    col_pos = nc;
  endtask

  task automatic check_point();
    stencil_point_t want;
    if (expected_points.size() == 0) begin
      report_mismatch($sformatf("unexpected point at (%0d,%0d) value %h",
                                row_index, col_index, new_value));
    end else begin
      want = expected_points.pop_front();
      if (new_value !== want.value)
        report_mismatch($sformatf("new_value at (%0d,%0d): got %h, want %h",
                                  want.row, want.col, new_value, want.value));
      if (row_index !== want.row)
        report_mismatch($sformatf("row_index: got %0d, want %0d", row_index, want.row));
      if (col_index !== want.col)
        report_mismatch($sformatf("col_index: got %0d, want %0d", col_index, want.col));
      if (last_point !== want.last)
        report_mismatch($sformatf("last_point at (%0d,%0d): got %b, want %b",
                                  want.row, want.col, last_point, want.last));
    end
  endtask

  // Monitor: every transaction is taken at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      in_accepted  <= 1'b0;
      cfg_accepted <= 1'b0;
    end else begin
      in_accepted  <= in_valid && in_ready;
      cfg_accepted <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready)
        set_register(cfg_reg_t'(cfg_index), cfg_data);
      if (in_valid && in_ready)
        advance_grid(sample, grid_start);
      if (out_valid && out_ready)
        check_point();
    end
  end

  // Sample driver: bursts of random length, random gaps between them when gap_limit is nonzero
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (gap_left > 0 || pending_samples.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0)
          gap_left--;
      end else begin
        next_item = pending_samples.pop_front();
        in_valid   <= 1'b1;
        sample     <= next_item.value;
        grid_start <= next_item.start;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = (gap_limit > 0) ? $urandom_range(1, gap_limit) : 0;
        end
      end
    end
  end

  // Result side stalls on a rotating pattern
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready   <= stall_pattern[stall_phase];
      stall_phase <= stall_phase + 4'd1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("heat_stencil_2d_sweep_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_accepted);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input int rows_raw, input int cols_raw, input int vert,
                           input int horz, input int centre, input bit red_black,
                           input bit parity);
    write_register(CFG_GRID_ROWS, CFG_DATA_W'(rows_raw));
    write_register(CFG_GRID_COLS, CFG_DATA_W'(cols_raw));
    write_register(CFG_COEF_VERT, CFG_DATA_W'(vert));
    write_register(CFG_COEF_HORZ, CFG_DATA_W'(horz));
    write_register(CFG_COEF_CENTRE, CFG_DATA_W'(centre));
    write_register(CFG_RED_BLACK, CFG_DATA_W'(red_black));
    write_register(CFG_COLOUR_PARITY, CFG_DATA_W'(parity));
    rows_now = clamp_rows(rows_raw);
    cols_now = clamp_cols(cols_raw);
  endtask

  task automatic push_sample(input logic [31:0] value, input logic start);
    grid_sample_t item;
    item.value = value;
    item.start = start;
    pending_samples.push_back(item);
  endtask

  function automatic logic [31:0] draw_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3, 4, 5: return $urandom_range(0, 1048576) - 32'd524288;
      default: return $urandom;
    endcase
  endfunction

  function automatic int draw_coef();
    case ($urandom_range(0, 6))
      0:       return -131072;
      1:       return 131071;
      2:       return 0;
      3:       return 65536;
      4:       return -65536;
      default: return int'($urandom_range(0, 262143)) - 131072;
    endcase
  endfunction

  task automatic queue_samples(input int count, input bit first_start);
    for (int k = 0; k < count; k++)
      push_sample(draw_sample(), first_start && (k == 0));
    samples_sent += count;
  endtask

  task automatic wait_results_drained();
    while (pending_samples.size() != 0 || in_valid || expected_points.size() != 0)
      @(posedge clk);
  endtask

  // samples that make no point may still be in the pipe
  task automatic drain_block();
    wait_results_drained();
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic pick_idling();
    case ($urandom_range(0, 3))
      0: begin
        gap_limit     = 0;
        stall_pattern = 16'hFFFF;
      end
      1: begin
        gap_limit     = 4;
        stall_pattern = 16'($urandom) | 16'h0001;
      end
      2: begin
        gap_limit     = 12;
        stall_pattern = 16'h0001 << $urandom_range(0, 15);
      end
      default: begin
        gap_limit     = $urandom_range(0, 2);
        stall_pattern = ~(16'h0001 << $urandom_range(0, 15));
      end
    endcase
  endtask

  initial begin
    int rows_raw, cols_raw, grids, grid_size, count;
    bit with_start, grid_open, pause_done;
    grid_open  = 1'b0;
    pause_done = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings, no grid_start: the point is the centre sample passed through
    push_sample(32'h7FFF_FFFF, 1'b0);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h0000_0001, 1'b0);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b0);
    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b0);
    drain_block();

    // largest weights, largest samples: positive saturation
    configure(3, 3, 131071, 131071, 131071, 1'b0, 1'b0);
    for (int k = 0; k < 9; k++)
      push_sample(32'h7FFF_FFFF, k == 0);
    drain_block();

    // sizes below minimum, red-black, back to back: negative saturation
    configure(2, 1, -131072, -131072, 131071, 1'b1, 1'b0);
    for (int k = 0; k < 9; k++)
      push_sample((k == 4) ? 32'h8000_0000 : 32'h7FFF_FFFF, 1'b0);
    drain_block();

    // columns lowered mid-row: the column counter is past the new width
    pick_idling();
    configure(4, 10, draw_coef(), draw_coef(), draw_coef(), 1'b0, 1'b0);
    queue_samples(7, 1'b1);
    drain_block();
    write_register(CFG_GRID_COLS, CFG_DATA_W'(5));
    queue_samples(4 * 5, 1'b0);
    drain_block();

    // rows lowered mid-grid: the stale row makes nothing, then the row wraps
    pick_idling();
    configure(8, 4, draw_coef(), draw_coef(), draw_coef(), 1'b1, $urandom_range(0, 1));
    queue_samples(5 * 4, 1'b1);
    drain_block();
    write_register(CFG_GRID_ROWS, CFG_DATA_W'(3));
    queue_samples(4 + 3 * 4, 1'b0);
    drain_block();

    // widest grid, columns above the line length
    pick_idling();
    configure(1, 2047, draw_coef(), draw_coef(), draw_coef(), $urandom_range(0, 1),
              $urandom_range(0, 1));
    queue_samples(3 * MAX_COLS, 1'b1);

    samples_sent = 0;
    while (samples_sent < RANDOM_ITEMS) begin
      drain_block();
      pick_idling();
      case ($urandom_range(0, 9))
        0:       rows_raw = $urandom_range(0, 2);
        1:       rows_raw = 65535;
        default: rows_raw = $urandom_range(3, 8);
      endcase
      cols_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      configure(rows_raw, cols_raw, draw_coef(), draw_coef(), draw_coef(),
                $urandom_range(0, 1), $urandom_range(0, 1));
      grids = $urandom_range(1, 3);
      for (int g = 0; g < grids; g++) begin
        grid_size = rows_now * cols_now;
        if (rows_raw == 65535)
          count = $urandom_range(3, 6) * cols_now + $urandom_range(0, cols_now - 1);
        else if ($urandom_range(0, 9) == 0)
          count = $urandom_range(1, grid_size - 1);
        else
          count = grid_size;
        // an unfinished grid must be restarted explicitly
        with_start = grid_open || ($urandom_range(0, 1) == 1);
        if (!pause_done || $urandom_range(0, 19) == 0) begin
          queue_samples(count - count / 2, with_start);
          wait_results_drained();
          queue_samples(count / 2, 1'b0);
          pause_done = 1'b1;
        end else begin
          queue_samples(count, with_start);
        end
        grid_open = (count != grid_size);
      end
    end

    drain_block();
    if (mismatch_count == 0)
      $display("heat_stencil_2d_sweep_core test passed");
    else
      $display("heat_stencil_2d_sweep_core test failed");
    $finish;
  end

endmodule
